FILE: hdl/rti_pkg.sv
// Shared types, widths and codes for the ray-triangle intersection pipeline.
package rti_pkg;

   // number format and datapath widths
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int EDGE_W     = DATA_W + 1;
   localparam int PROD_W     = 2 * EDGE_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int SPLIT      = 34;
   localparam int LO_W       = EDGE_W + SPLIT + 1;
   localparam int HI_W       = EDGE_W + CROSS_W - SPLIT;
   localparam int WIDE_W     = 104;
   localparam int DIST_W     = 31;
   localparam int REM_W      = WIDE_W + FRAC_BITS + DIST_W;
   localparam int PRE_STAGES = 8;
   localparam int LATENCY    = PRE_STAGES + DIST_W + 1;
   localparam int CSR_IDX_W  = 3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Z    = 3'd5;

   // miss cause codes
   localparam logic [2:0] CAUSE_HIT      = 3'd0;
   localparam logic [2:0] CAUSE_PARALLEL = 3'd1;
   localparam logic [2:0] CAUSE_U_OUT    = 3'd2;
   localparam logic [2:0] CAUSE_V_OUT    = 3'd3;
   localparam logic [2:0] CAUSE_BEHIND   = 3'd4;

   // unit direction along z after reset
   localparam logic signed [DATA_W-1:0] DIR_Z_RESET = DATA_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic signed [DATA_W-1:0] v0_x;
      logic signed [DATA_W-1:0] v0_y;
      logic signed [DATA_W-1:0] v0_z;
      logic signed [DATA_W-1:0] v1_x;
      logic signed [DATA_W-1:0] v1_y;
      logic signed [DATA_W-1:0] v1_z;
      logic signed [DATA_W-1:0] v2_x;
      logic signed [DATA_W-1:0] v2_y;
      logic signed [DATA_W-1:0] v2_z;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [2:0]        miss_cause;
      logic [DIST_W-1:0] distance;
   } rsp_type;

endpackage

FILE: hdl/ray_triangle_intersection.sv
// Top level: pipelined fixed-point ray-triangle intersection test.
//
// Usage: the ray (origin and direction, signed Q16.16) is loaded through the
// csr_ write channel; csr_ready is always high and a write lands when
// csr_valid is high. Write the ray only while no request is in flight.
// Each request is one triangle on req_item, accepted at a clock edge with
// start high and busy low. busy stays low, so a new triangle may enter
// every clock cycle: throughput is one request per cycle.
// The pipeline has eight stages for edges, cross products, the split
// dot products, sums, sign fix-up and classification, then one stage per
// distance bit (31) of a restoring divider, then the output register.
// The result shows on rsp_item for exactly one cycle with rsp_strobe high;
// results come out in request order and the receiver cannot hold them off.
// A synchronous reset empties the pipeline, dropping requests in flight,
// and restores origin (0,0,0) and direction (0,0,1.0).
module ray_triangle_intersection
   import rti_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_strobe,
   output rsp_type              rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   // ray registers
   logic signed [DATA_W-1:0] org_ff [3];
   logic signed [DATA_W-1:0] dir_ff [3];

   // valid bits per pre-divider stage
   logic [PRE_STAGES-1:0] vld_ff;
   logic [PRE_STAGES-1:0] vld_in;

   // stage 1: edges
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [EDGE_W-1:0] tv_ff [3];
   logic signed [EDGE_W-1:0] v0_w [3];
   logic signed [EDGE_W-1:0] v1_w [3];
   logic signed [EDGE_W-1:0] v2_w [3];

   // stage 2: cross product terms
   logic signed [PROD_W-1:0] pa_ff [3];
   logic signed [PROD_W-1:0] pb_ff [3];
   logic signed [PROD_W-1:0] qa_ff [3];
   logic signed [PROD_W-1:0] qb_ff [3];
   logic signed [EDGE_W-1:0] e1_s2_ff [3];
   logic signed [EDGE_W-1:0] e2_s2_ff [3];
   logic signed [EDGE_W-1:0] tv_s2_ff [3];

   // stage 3: cross products
   logic signed [CROSS_W-1:0] p_ff [3];
   logic signed [CROSS_W-1:0] q_ff [3];
   logic signed [EDGE_W-1:0]  e1_s3_ff [3];
   logic signed [EDGE_W-1:0]  e2_s3_ff [3];
   logic signed [EDGE_W-1:0]  tv_s3_ff [3];

   // stage 4: split dot product partials (det, u, v, t)
   logic signed [EDGE_W-1:0]  xa_w [4][3];
   logic signed [CROSS_W-1:0] yb_w [4][3];
   logic signed [LO_W-1:0]    lo_ff [4][3];
   logic signed [HI_W-1:0]    hi_ff [4][3];

   // stage 5: full products
   logic signed [WIDE_W-1:0] term_ff [4][3];

   // stage 6: dot products
   logic signed [WIDE_W-1:0] sum_ff [4];

   // stage 7: sign normalized numerators
   logic signed [WIDE_W-1:0] det_ff;
   logic signed [WIDE_W-1:0] un_ff;
   logic signed [WIDE_W-1:0] vn_ff;
   logic signed [WIDE_W-1:0] tn_ff;
   logic                     det_zero_ff;

   // stage 8: classification and divider setup
   logic [2:0]        cause_ff;
   logic [2:0]        cause_in;
   logic              sat_ff;
   logic [REM_W-1:0]  num_ff;
   logic [REM_W-1:0]  num_in;
   logic [WIDE_W-1:0] den_ff;

   // divider stages
   logic              dv_ff    [DIST_W];
   logic [REM_W-1:0]  drem_ff  [DIST_W];
   logic [WIDE_W-1:0] dden_ff  [DIST_W];
   logic [DIST_W-1:0] dq_ff    [DIST_W];
   logic [2:0]        dcause_ff[DIST_W];
   logic              dsat_ff  [DIST_W];

   // output register
   logic    rsp_strobe_ff;
   rsp_type rsp_item_ff;
   rsp_type rsp_item_in;

   assign busy       = 1'b0;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // write ray registers
   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= DIR_Z_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ORIGIN_X: org_ff[0] <= csr_data;
            REG_ORIGIN_Y: org_ff[1] <= csr_data;
            REG_ORIGIN_Z: org_ff[2] <= csr_data;
            REG_DIR_X:    dir_ff[0] <= csr_data;
            REG_DIR_Y:    dir_ff[1] <= csr_data;
            REG_DIR_Z:    dir_ff[2] <= csr_data;
            default:      ;
         endcase
      end
   end

   // advance valid bits
   always_comb begin
      vld_in = {vld_ff[PRE_STAGES-2:0], start & ~busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld_ff        <= vld_in;
         rsp_strobe_ff <= dv_ff[DIST_W-1];
      end
   end

   // widen vertices
   always_comb begin
      v0_w[0] = EDGE_W'(req_item.v0_x);
      v0_w[1] = EDGE_W'(req_item.v0_y);
      v0_w[2] = EDGE_W'(req_item.v0_z);
      v1_w[0] = EDGE_W'(req_item.v1_x);
      v1_w[1] = EDGE_W'(req_item.v1_y);
      v1_w[2] = EDGE_W'(req_item.v1_z);
      v2_w[0] = EDGE_W'(req_item.v2_x);
      v2_w[1] = EDGE_W'(req_item.v2_y);
      v2_w[2] = EDGE_W'(req_item.v2_z);
   end

   // stages 1 to 3: edges and cross products
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e1_ff[i] <= v1_w[i] - v0_w[i];
         e2_ff[i] <= v2_w[i] - v0_w[i];
         tv_ff[i] <= EDGE_W'(org_ff[i]) - v0_w[i];
      end

      pa_ff[0] <= EDGE_W'(dir_ff[1]) * e2_ff[2];
      pb_ff[0] <= EDGE_W'(dir_ff[2]) * e2_ff[1];
      pa_ff[1] <= EDGE_W'(dir_ff[2]) * e2_ff[0];
      pb_ff[1] <= EDGE_W'(dir_ff[0]) * e2_ff[2];
      pa_ff[2] <= EDGE_W'(dir_ff[0]) * e2_ff[1];
      pb_ff[2] <= EDGE_W'(dir_ff[1]) * e2_ff[0];
      qa_ff[0] <= tv_ff[1] * e1_ff[2];
      qb_ff[0] <= tv_ff[2] * e1_ff[1];
      qa_ff[1] <= tv_ff[2] * e1_ff[0];
      qb_ff[1] <= tv_ff[0] * e1_ff[2];
      qa_ff[2] <= tv_ff[0] * e1_ff[1];
      qb_ff[2] <= tv_ff[1] * e1_ff[0];

      for (int i = 0; i < 3; i++) begin
         e1_s2_ff[i] <= e1_ff[i];
         e2_s2_ff[i] <= e2_ff[i];
         tv_s2_ff[i] <= tv_ff[i];
         p_ff[i]     <= CROSS_W'(pa_ff[i]) - CROSS_W'(pb_ff[i]);
         q_ff[i]     <= CROSS_W'(qa_ff[i]) - CROSS_W'(qb_ff[i]);
         e1_s3_ff[i] <= e1_s2_ff[i];
         e2_s3_ff[i] <= e2_s2_ff[i];
         tv_s3_ff[i] <= tv_s2_ff[i];
      end
   end

   // pick dot product operands: det = e1.P, u = T.P, v = D.Q, t = e2.Q
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xa_w[0][i] = e1_s3_ff[i];
         yb_w[0][i] = p_ff[i];
         xa_w[1][i] = tv_s3_ff[i];
         yb_w[1][i] = p_ff[i];
         xa_w[2][i] = EDGE_W'(dir_ff[i]);
         yb_w[2][i] = q_ff[i];
         xa_w[3][i] = e2_s3_ff[i];
         yb_w[3][i] = q_ff[i];
      end
   end

   // stages 4 to 7: split multiply, recombine, sum, fix sign
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[k][i]   <= xa_w[k][i] * $signed({1'b0, yb_w[k][i][SPLIT-1:0]});
            hi_ff[k][i]   <= xa_w[k][i] * $signed(yb_w[k][i][CROSS_W-1:SPLIT]);
            term_ff[k][i] <= WIDE_W'(lo_ff[k][i]) + (WIDE_W'(hi_ff[k][i]) <<< SPLIT);
         end
         sum_ff[k] <= term_ff[k][0] + term_ff[k][1] + term_ff[k][2];
      end

      det_zero_ff <= (sum_ff[0] == '0);
      if (sum_ff[0] < 0) begin
         det_ff <= -sum_ff[0];
         un_ff  <= -sum_ff[1];
         vn_ff  <= -sum_ff[2];
         tn_ff  <= -sum_ff[3];
      end else begin
         det_ff <= sum_ff[0];
         un_ff  <= sum_ff[1];
         vn_ff  <= sum_ff[2];
         tn_ff  <= sum_ff[3];
      end
   end

   // classify the miss and scale the distance numerator
   always_comb begin
      num_in = REM_W'(tn_ff) << FRAC_BITS;
      if (det_zero_ff) begin
         cause_in = CAUSE_PARALLEL;
      end else if (un_ff < 0 || un_ff > det_ff) begin
         cause_in = CAUSE_U_OUT;
      end else if (vn_ff < 0 ||
                   ((WIDE_W + 1)'(un_ff) + (WIDE_W + 1)'(vn_ff)) > (WIDE_W + 1)'(det_ff)) begin
         cause_in = CAUSE_V_OUT;
      end else if (tn_ff <= 0) begin
         cause_in = CAUSE_BEHIND;
      end else begin
         cause_in = CAUSE_HIT;
      end
   end

   // stage 8: hold classification, flag saturation
   always_ff @(posedge clock) begin
      cause_ff <= cause_in;
      num_ff   <= (cause_in == CAUSE_HIT) ? num_in : '0;
      den_ff   <= det_ff;
      sat_ff   <= num_in >= (REM_W'(det_ff) << DIST_W);
   end

   // restoring divider, one quotient bit per stage, high bit first
   for (genvar k = 0; k < DIST_W; k++) begin : g_div
      localparam int BIT = DIST_W - 1 - k;
      logic [REM_W-1:0]  rem_w;
      logic [WIDE_W-1:0] den_w;
      logic [DIST_W-1:0] q_w;
      logic [REM_W-1:0]  shd_w;
      logic [REM_W-1:0]  drem_in;
      logic [DIST_W-1:0] dq_in;

      if (k == 0) begin : g_first
         always_comb begin
            rem_w = num_ff;
            den_w = den_ff;
            q_w   = '0;
         end
         always_ff @(posedge clock) begin
            dcause_ff[k] <= cause_ff;
            dsat_ff[k]   <= sat_ff;
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_ff[k] <= 1'b0;
            end else begin
               dv_ff[k] <= vld_ff[PRE_STAGES-1];
            end
         end
      end else begin : g_next
         always_comb begin
            rem_w = drem_ff[k-1];
            den_w = dden_ff[k-1];
            q_w   = dq_ff[k-1];
         end
         always_ff @(posedge clock) begin
            dcause_ff[k] <= dcause_ff[k-1];
            dsat_ff[k]   <= dsat_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_ff[k] <= 1'b0;
            end else begin
               dv_ff[k] <= dv_ff[k-1];
            end
         end
      end

      // compare and subtract the shifted divisor
      always_comb begin
         shd_w   = REM_W'(den_w) << BIT;
         drem_in = rem_w;
         dq_in   = q_w;
         if (rem_w >= shd_w) begin
            drem_in    = rem_w - shd_w;
            dq_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         drem_ff[k] <= drem_in;
         dden_ff[k] <= den_w;
         dq_ff[k]   <= dq_in;
      end
   end

   // form the result
   always_comb begin
      rsp_item_in.hit        = (dcause_ff[DIST_W-1] == CAUSE_HIT);
      rsp_item_in.miss_cause = dcause_ff[DIST_W-1];
      if (dcause_ff[DIST_W-1] != CAUSE_HIT) begin
         rsp_item_in.distance = '0;
      end else if (dsat_ff[DIST_W-1]) begin
         rsp_item_in.distance = '1;
      end else begin
         rsp_item_in.distance = dq_ff[DIST_W-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

endmodule

FILE: hdl/rti_checker.sv
// Port checker for the ray-triangle intersection block, bound to the top level.
module rti_checker
   import rti_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // every request yields one result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("result missing after request");

   // no result without a request
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_strobe)
      else $error("result without request");

   // hit flag and cause agree
   a_hit_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.hit == (rsp_item.miss_cause == CAUSE_HIT)))
      else $error("hit flag and cause disagree");

   // a miss reports zero distance and a known cause
   a_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.hit) |->
         (rsp_item.distance == '0 &&
          (rsp_item.miss_cause == CAUSE_PARALLEL || rsp_item.miss_cause == CAUSE_U_OUT ||
           rsp_item.miss_cause == CAUSE_V_OUT || rsp_item.miss_cause == CAUSE_BEHIND)))
      else $error("bad miss result");

endmodule

bind ray_triangle_intersection rti_checker u_rti_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

FILE: tb/ray_triangle_intersection_tb.sv
// Self-checking testbench for the pipelined ray-triangle intersection block.
module ray_triangle_intersection_tb;
   import rti_pkg::*;

   localparam int WD_LIMIT = 4000;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_item;
   logic                 rsp_strobe;
   rsp_type              rsp_item;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_data;

   ray_triangle_intersection i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // ray registers as the predictor sees them
   logic signed [DATA_W-1:0] ray_reg [6];

   req_type     triangle_queue[$];
   rsp_type     hit_queue[$];
   int          error_count;
   int          idle_cycles;
   int          gap_left;
   bit          hold_driver;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // predict the hit test for one triangle against the current ray
   function automatic rsp_type predict_hit(req_type tri_in);
      logic signed [127:0] v0 [3], v1 [3], v2 [3], org [3], dir [3];
      logic signed [127:0] e1 [3], e2 [3], tv [3], pv [3], qv [3];
      logic signed [127:0] det, un, vn, tn;
      logic [127:0]        quot;
      rsp_type             r;
      v0[0] = tri_in.v0_x; v0[1] = tri_in.v0_y; v0[2] = tri_in.v0_z;
      v1[0] = tri_in.v1_x; v1[1] = tri_in.v1_y; v1[2] = tri_in.v1_z;
      v2[0] = tri_in.v2_x; v2[1] = tri_in.v2_y; v2[2] = tri_in.v2_z;
      for (int i = 0; i < 3; i++) begin
         org[i] = ray_reg[i];
         dir[i] = ray_reg[3+i];
         e1[i] = v1[i] - v0[i];
         e2[i] = v2[i] - v0[i];
         tv[i] = org[i] - v0[i];
      end
      pv[0] = dir[1]*e2[2] - dir[2]*e2[1];
      pv[1] = dir[2]*e2[0] - dir[0]*e2[2];
      pv[2] = dir[0]*e2[1] - dir[1]*e2[0];
      qv[0] = tv[1]*e1[2] - tv[2]*e1[1];
      qv[1] = tv[2]*e1[0] - tv[0]*e1[2];
      qv[2] = tv[0]*e1[1] - tv[1]*e1[0];
      det = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
      un  = tv[0]*pv[0] + tv[1]*pv[1] + tv[2]*pv[2];
      vn  = dir[0]*qv[0] + dir[1]*qv[1] + dir[2]*qv[2];
      tn  = e2[0]*qv[0] + e2[1]*qv[1] + e2[2]*qv[2];
      r = '0;
      r.miss_cause = CAUSE_HIT;
      if (det == 0) begin
         r.miss_cause = CAUSE_PARALLEL;
      end else begin
         // fold the winding so one set of tests serves both
         if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
         end
         if (un < 0 || un > det) r.miss_cause = CAUSE_U_OUT;
         else if (vn < 0 || un + vn > det) r.miss_cause = CAUSE_V_OUT;
         else if (tn <= 0) r.miss_cause = CAUSE_BEHIND;
         else begin
            quot = (128'(tn) << FRAC_BITS) / 128'(det);
            r.hit = 1'b1;
            r.distance = (quot > 128'h7FFF_FFFF) ? 31'h7FFF_FFFF : quot[DIST_W-1:0];
         end
      end
      return r;
   endfunction

   // append one triangle to the pending requests
   task automatic queue_triangle(input req_type item);
      triangle_queue.insert(triangle_queue.size(), item);
   endtask

   // write one ray register while the pipeline is empty
   task automatic write_ray(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx < 6) ray_reg[idx] = val;
   endtask

   // wait until the pipeline has drained and settled
   task automatic drain;
      wait (triangle_queue.size() == 0 && !start);
      wait (hit_queue.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] rand_coord(input int scale);
      case (scale)
         0: return $urandom;
         1: return DATA_W'($signed($urandom_range(0, 2*65536*8)) - 65536*8);
         default: return DATA_W'($signed($urandom_range(0, 2*65536*256)) - 65536*256);
      endcase
   endfunction

   function automatic req_type rand_triangle(input int scale);
      req_type t;
      t.v0_x = rand_coord(scale); t.v0_y = rand_coord(scale); t.v0_z = rand_coord(scale);
      t.v1_x = rand_coord(scale); t.v1_y = rand_coord(scale); t.v1_z = rand_coord(scale);
      t.v2_x = rand_coord(scale); t.v2_y = rand_coord(scale); t.v2_z = rand_coord(scale);
      return t;
   endfunction

   // triangle straddling the ray near the origin: mostly hits, some edge misses
   function automatic req_type aimed_triangle();
      req_type t;
      logic signed [DATA_W-1:0] cx, cy, cz, s;
      cx = ray_reg[0] + ray_reg[3] * $signed($urandom_range(0, 6)) - 32768;
      cy = ray_reg[1] + ray_reg[4] * $signed($urandom_range(0, 6));
      cz = ray_reg[2] + ray_reg[5] * $signed($urandom_range(0, 6))
           - $signed($urandom_range(0, 3) * 65536);
      s = $signed($urandom_range(1 << 14, 4 << 16));
      t.v0_x = cx - s;  t.v0_y = cy - s;  t.v0_z = cz + rand_coord(1) / 4;
      t.v1_x = cx + s;  t.v1_y = cy - s;  t.v1_z = cz + rand_coord(1) / 4;
      t.v2_x = cx + (s >>> $urandom_range(0, 3));  t.v2_y = cy + s;
      t.v2_z = cz + rand_coord(1) / 4;
      return t;
   endfunction

   // feed requests into the pipeline with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_item <= '0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            hit_queue.insert(hit_queue.size(), predict_hit(req_item));
         end
         if (start && busy) begin
            // hold the request until accepted
         end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (triangle_queue.size() > 0 && !hold_driver) begin
            start    <= 1'b1;
            req_item <= triangle_queue.pop_front();
            case ($urandom_range(0, 9))
               0, 1:    gap_left <= $urandom_range(1, 3);
               2:       gap_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : 0;
               default: gap_left <= 0;
            endcase
         end else begin
            start <= 1'b0;
         end
      end
   end

   // check each result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (hit_queue.size() == 0) begin
            $error("unexpected result: hit %0d cause %0d distance %0d",
                   rsp_item.hit, rsp_item.miss_cause, rsp_item.distance);
            error_count++;
         end else begin
            rsp_type exp_rsp;
            exp_rsp = hit_queue.pop_front();
            if (rsp_item.hit !== exp_rsp.hit) begin
               $error("hit: expected %0d, actual %0d", exp_rsp.hit, rsp_item.hit);
               error_count++;
            end
            if (rsp_item.miss_cause !== exp_rsp.miss_cause) begin
               $error("miss_cause: expected %0d, actual %0d",
                      exp_rsp.miss_cause, rsp_item.miss_cause);
               error_count++;
            end
            if (rsp_item.distance !== exp_rsp.distance) begin
               $error("distance: expected %0d, actual %0d",
                      exp_rsp.distance, rsp_item.distance);
               error_count++;
            end
         end
      end
   end

   // stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WD_LIMIT) begin
            $display("ray_triangle_intersection_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      req_type t;
      hold_driver = 1'b0;
      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      for (int i = 0; i < 6; i++) ray_reg[i] = '0;
      ray_reg[REG_DIR_Z] = DIR_Z_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset ray along +z
      t = '{default: '0};
      t.v0_x = -65536; t.v0_y = -65536; t.v0_z = 5 << 16;
      t.v1_x = 65536;  t.v1_y = -65536; t.v1_z = 5 << 16;
      t.v2_x = 0;      t.v2_y = 65536;  t.v2_z = 5 << 16;
      queue_triangle(t);                                 // plain hit
      t.v0_z = -(5 << 16); t.v1_z = -(5 << 16); t.v2_z = -(5 << 16);
      queue_triangle(t);                                 // behind
      t.v0_z = 0; t.v1_z = 0; t.v2_z = 0;
      queue_triangle(t);                                 // t exactly zero
      t.v0_x = 2 << 16; t.v1_x = 4 << 16; t.v2_x = 3 << 16;
      t.v0_z = 65536; t.v1_z = 65536; t.v2_z = 65536;
      queue_triangle(t);                                 // u outside
      t.v0_x = -65536; t.v1_x = 65536; t.v2_x = 0;
      t.v0_y = 2 << 16; t.v1_y = 2 << 16; t.v2_y = 4 << 16;
      queue_triangle(t);                                 // v outside
      t = '{default: '0};
      t.v1_z = 65536; t.v2_x = 65536;
      queue_triangle(t);                                 // parallel to the ray
      queue_triangle('{default: '0});                    // degenerate
      t.v0_x = 0; t.v0_y = 0; t.v0_z = 65536;
      t.v1_x = 65536; t.v1_y = 0; t.v1_z = 65536;
      t.v2_x = 0; t.v2_y = 65536; t.v2_z = 65536;
      queue_triangle(t);                                 // hit point on a vertex and edges
      t.v0_z = 1; t.v1_z = 1; t.v2_z = 1;
      queue_triangle(t);                                 // tiny t, smallest nonzero distance
      t.v0_z = 32'h7FFF_FFFF; t.v1_z = 32'h7FFF_FFFF; t.v2_z = 32'h7FFF_FFFF;
      queue_triangle(t);                                 // far hit
      t.v0_x = 32'h8000_0000; t.v1_x = 32'h7FFF_FFFF; t.v2_x = 32'h8000_0000;
      t.v0_y = 32'h8000_0000; t.v1_y = 32'h8000_0000; t.v2_y = 32'h7FFF_FFFF;
      t.v0_z = 32'h8000_0000; t.v1_z = 32'h7FFF_FFFF; t.v2_z = 32'h7FFF_FFFF;
      queue_triangle(t);                                 // extreme coordinates
      t = '{default: 32'hFFFF_FFFF};
      queue_triangle(t);
      t = '{default: 32'h7FFF_FFFF};
      queue_triangle(t);
      drain();

      // saturation: almost parallel ray toward a far plane
      write_ray(REG_DIR_Z, 32'd1);
      t = '{default: '0};
      t.v0_x = -65536; t.v0_y = -65536; t.v0_z = 32'h4000_0000;
      t.v1_x = 65536;  t.v1_y = -65536; t.v1_z = 32'h4000_0000;
      t.v2_x = 0;      t.v2_y = 65536;  t.v2_z = 32'h4000_0000;
      queue_triangle(t);
      t.v0_z = 65536; t.v1_z = 65536; t.v2_z = 65536;
      queue_triangle(t);
      drain();
      write_ray(3'd6, 32'hDEAD_BEEF);                    // ignored index
      write_ray(3'd7, 32'h1234_5678);

      // random phases, each with a new ray, extremes first
      for (int ph = 0; ph < 10; ph++) begin
         for (int r = 0; r < 6; r++) begin
            logic [DATA_W-1:0] val;
            case (ph)
               0: val = (r < 3) ? 32'h8000_0000 : 32'h7FFF_FFFF;
               1: val = (r < 3) ? 32'h7FFF_FFFF : 32'h8000_0000;
               2: val = $urandom;
               default: val = (r < 3) ? rand_coord(1) : rand_coord(1) / 4;
            endcase
            write_ray(CSR_IDX_W'(r), val);
         end
         for (int n = 0; n < 43; n++) begin
            case ($urandom_range(0, 9))
               0:       t = rand_triangle(0);
               1:       t = rand_triangle(2);
               2:       t = rand_triangle(1);
               default: t = aimed_triangle();
            endcase
            queue_triangle(t);
         end
         // let the pipeline run dry once mid-phase
         if (ph == 4) begin
            wait (triangle_queue.size() == 0);
            hold_driver = 1'b1;
            wait (hit_queue.size() == 0 && !start);
            hold_driver = 1'b0;
            for (int n = 0; n < 10; n++) queue_triangle(aimed_triangle());
         end
         drain();
      end

      if (error_count == 0) begin
         $display("ray_triangle_intersection_tb: clean");
      end else begin
         $display("ray_triangle_intersection_tb: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/rti_pkg.sv
hdl/ray_triangle_intersection.sv
hdl/rti_checker.sv
tb/ray_triangle_intersection_tb.sv
